// ----- hw/rtl/sfvs_pkg.sv -----
// Shared types, constants, microprogram and sine table of the sine force Verlet step unit.
`timescale 1ns / 1ps

package sfvs_pkg;

	localparam int RUN_LENGTH = 4096;
	localparam int STEP_W = 12;
	localparam int SINE_ENTRIES = 256;
	localparam int SINE_ADDR_W = $clog2(SINE_ENTRIES);
	localparam int UPC_W = 4;
	localparam int PROGRAM_DEPTH = 16;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [UPC_W-1:0] upc_t;

	localparam upc_t UPC_IDLE = 4'd0;
	localparam upc_t UPC_KICK = 4'd5;

	typedef enum logic [1:0] {
		CFG_FORCE_GAIN     = 2'd0,
		CFG_TIME_STEP      = 2'd1,
		CFG_HALF_TIME_STEP = 2'd2,
		CFG_PHASE_PER_UNIT = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		SEQ_NEXT     = 2'd0,
		SEQ_WAIT_IN  = 2'd1,
		SEQ_WAIT_OUT = 2'd2
	} seq_op_t;

	typedef enum logic [2:0] {
		MUL_NONE  = 3'd0,
		MUL_PHASE = 3'd1,
		MUL_FORCE = 3'd2,
		MUL_KICK  = 3'd3,
		MUL_DRIFT = 3'd4
	} mul_op_t;

	typedef enum logic [2:0] {
		WR_NONE  = 3'd0,
		WR_SINE  = 3'd1,
		WR_FORCE = 3'd2,
		WR_VH    = 3'd3,
		WR_POS   = 3'd4,
		WR_VEL   = 3'd5
	} wr_op_t;

	typedef struct packed {
		seq_op_t seq_op;
		mul_op_t mul_op;
		wr_op_t  wr_op;
		upc_t    target;
	} ctl_t;

	typedef struct packed {
		logic load_start;
		logic emit;
	} seq_status_t;

	typedef struct packed {
		logic        start_req;
		logic [31:0] initial_position;
	} in_t;

	typedef struct packed {
		logic [STEP_W-1:0] step_index;
		logic [31:0]       position;
		logic [31:0]       velocity;
		logic              last_step;
	} out_t;

	typedef struct packed {
		logic signed [31:0] force_gain;
		logic [30:0]        time_step;
		logic [30:0]        half_time_step;
		logic [31:0]        phase_per_unit;
	} cfg_t;

	typedef ctl_t program_t [PROGRAM_DEPTH];

	localparam program_t PROGRAM = '{
		'{SEQ_WAIT_IN,  MUL_NONE,  WR_NONE,  UPC_KICK},
		'{SEQ_NEXT,     MUL_PHASE, WR_NONE,  UPC_IDLE},
		'{SEQ_NEXT,     MUL_NONE,  WR_SINE,  UPC_IDLE},
		'{SEQ_NEXT,     MUL_FORCE, WR_NONE,  UPC_IDLE},
		'{SEQ_NEXT,     MUL_NONE,  WR_FORCE, UPC_IDLE},
		'{SEQ_NEXT,     MUL_KICK,  WR_NONE,  UPC_IDLE},
		'{SEQ_NEXT,     MUL_NONE,  WR_VH,    UPC_IDLE},
		'{SEQ_NEXT,     MUL_DRIFT, WR_NONE,  UPC_IDLE},
		'{SEQ_NEXT,     MUL_NONE,  WR_POS,   UPC_IDLE},
		'{SEQ_NEXT,     MUL_PHASE, WR_NONE,  UPC_IDLE},
		'{SEQ_NEXT,     MUL_NONE,  WR_SINE,  UPC_IDLE},
		'{SEQ_NEXT,     MUL_FORCE, WR_NONE,  UPC_IDLE},
		'{SEQ_NEXT,     MUL_NONE,  WR_FORCE, UPC_IDLE},
		'{SEQ_NEXT,     MUL_KICK,  WR_NONE,  UPC_IDLE},
		'{SEQ_NEXT,     MUL_NONE,  WR_VEL,   UPC_IDLE},
		'{SEQ_WAIT_OUT, MUL_NONE,  WR_NONE,  UPC_IDLE}
	};

	typedef logic [15:0] sine_rom_t [SINE_ENTRIES];

	// Quarter-wave sine sampled at bin centers with a truncating Q2.30 Taylor series.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] e;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			x = (HALF_PI_Q30 * 64'(2 * i + 1)) / (2 * SINE_ENTRIES);
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			term = ((term * x2) >> 30) / 6;
			sum = sum - term;
			term = ((term * x2) >> 30) / 20;
			sum = sum + term;
			term = ((term * x2) >> 30) / 42;
			sum = sum - term;
			term = ((term * x2) >> 30) / 72;
			sum = sum + term;
			term = ((term * x2) >> 30) / 110;
			sum = sum - term;
			term = ((term * x2) >> 30) / 156;
			sum = sum + term;
			term = ((term * x2) >> 30) / 210;
			sum = sum - term;
			e = ((sum << 16) + (64'd1 << 29)) >> 30;
			if (e > 64'd65535) begin
				e = 64'd65535;
			end
			rom[i] = e[15:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- hw/rtl/sfvs_sequencer.sv -----
// Microprogram sequencer: microprogram counter, control word store and conditional jumps.
`timescale 1ns / 1ps

module sfvs_sequencer import sfvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_start,
	input  logic        out_free,
	output ctl_t        ctl,
	output seq_status_t status,
	output logic        in_stall
);

	upc_t upc_q;
	upc_t upc_next;

	assign ctl = PROGRAM[upc_q];
	assign in_stall = (ctl.seq_op != SEQ_WAIT_IN);

	always_comb begin
		upc_next = upc_q;
		status.load_start = 1'b0;
		status.emit = 1'b0;
		unique case (ctl.seq_op)
			SEQ_NEXT: begin
				upc_next = upc_q + upc_t'(1);
			end
			SEQ_WAIT_IN: begin
				if (in_valid) begin
					status.load_start = in_start;
					upc_next = in_start ? upc_q + upc_t'(1) : ctl.target;
				end
			end
			SEQ_WAIT_OUT: begin
				if (out_free) begin
					status.emit = 1'b1;
					upc_next = ctl.target;
				end
			end
			default: begin
				upc_next = UPC_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

// ----- hw/rtl/sfvs_datapath.sv -----
// Datapath with one shared multiplier, a saturating adder, the sine table and the particle state.
`timescale 1ns / 1ps

module sfvs_datapath import sfvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	input  seq_status_t status,
	input  cfg_t        cfg,
	input  logic [31:0] initial_position,
	output out_t        result
);

	logic signed [31:0] pos_q;
	logic signed [31:0] vel_q;
	logic signed [31:0] force_q;
	logic signed [31:0] vh_q;
	logic signed [16:0] sine_q;
	logic [STEP_W-1:0]  cnt_q;
	logic signed [65:0] prod_q;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;

	logic [31:0]            phase;
	logic [SINE_ADDR_W-1:0] sine_idx;
	logic [15:0]            sine_mag;
	logic signed [16:0]     sine_next;

	logic signed [31:0] add_a;
	logic signed [50:0] sum;
	logic signed [31:0] sum_sat;

	always_comb begin
		unique case (ctl.mul_op)
			MUL_PHASE: begin
				mul_a = 33'(pos_q);
				mul_b = $signed({1'b0, cfg.phase_per_unit});
			end
			MUL_FORCE: begin
				mul_a = 33'(cfg.force_gain);
				mul_b = 33'(sine_q);
			end
			MUL_KICK: begin
				mul_a = 33'(force_q);
				mul_b = $signed({2'b00, cfg.half_time_step});
			end
			MUL_DRIFT: begin
				mul_a = 33'(vh_q);
				mul_b = $signed({2'b00, cfg.time_step});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign phase = prod_q[47:16];

	always_comb begin
		sine_idx = phase[29 -: SINE_ADDR_W];
		if (phase[30]) begin
			sine_idx = ~sine_idx;
		end
		sine_mag = SINE_ROM[sine_idx];
		sine_next = phase[31] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
	end

	always_comb begin
		unique case (ctl.wr_op)
			WR_VH:   add_a = vel_q;
			WR_POS:  add_a = pos_q;
			WR_VEL:  add_a = vh_q;
			default: add_a = '0;
		endcase
		sum = 51'(add_a) + 51'($signed(prod_q[65:16]));
		if ((sum[50:31] != '0) && (sum[50:31] != '1)) begin
			sum_sat = sum[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sum_sat = sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_op == WR_SINE) begin
			sine_q <= sine_next;
		end
		if (ctl.wr_op == WR_VH) begin
			vh_q <= sum_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			vel_q <= '0;
			force_q <= '0;
			cnt_q <= '0;
		end else begin
			if (status.load_start) begin
				pos_q <= initial_position;
				vel_q <= '0;
				cnt_q <= '0;
			end
			if (ctl.wr_op == WR_FORCE) begin
				force_q <= sum_sat;
			end
			if (ctl.wr_op == WR_POS) begin
				pos_q <= sum_sat;
			end
			if (ctl.wr_op == WR_VEL) begin
				vel_q <= sum_sat;
			end
			if (status.emit) begin
				cnt_q <= (cnt_q == STEP_W'(RUN_LENGTH - 1)) ? '0 : cnt_q + STEP_W'(1);
			end
		end
	end

	assign result.step_index = cnt_q;
	assign result.position = pos_q;
	assign result.velocity = vel_q;
	assign result.last_step = (cnt_q == STEP_W'(RUN_LENGTH - 1));

endmodule

// ----- hw/rtl/sine_force_verlet_step_unit.sv -----
// Top level of the sine force Verlet step unit: configuration registers, sequencer, datapath, output register.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Beat
// in       input      in_valid / in_stall  start_req, initial_position
// out      output     out_valid / out_stall step_index, position, velocity, last_step
// cfg      input      cfg_we               cfg_index, cfg_data
//
// A step is paced by the single shared multiplier; a start beat adds a force evaluation first.
// Reset clears the microprogram counter, the state and loads the configuration defaults.
// A finished result waits in the output register while the next input beat is taken;
// a stalled output holds the sequencer at its final step until the register frees.

module sine_force_verlet_step_unit import sfvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t        cfg_q;
	ctl_t        ctl;
	seq_status_t status;
	out_t        result;
	out_t        out_data_q;
	logic        out_valid_q;
	logic        out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.force_gain <= '0;
			cfg_q.time_step <= 31'd23999;
			cfg_q.half_time_step <= 31'd12000;
			cfg_q.phase_per_unit <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_FORCE_GAIN:     cfg_q.force_gain <= cfg_data;
				CFG_TIME_STEP:      cfg_q.time_step <= cfg_data[30:0];
				CFG_HALF_TIME_STEP: cfg_q.half_time_step <= cfg_data[30:0];
				CFG_PHASE_PER_UNIT: cfg_q.phase_per_unit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	sfvs_sequencer u_sequencer (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_start (in_data.start_req),
		.out_free (out_free),
		.ctl      (ctl),
		.status   (status),
		.in_stall (in_stall)
	);

	sfvs_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.status           (status),
		.cfg              (cfg_q),
		.initial_position (in_data.initial_position),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (status.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.emit) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

// ----- dv/sine_force_verlet_step_unit_checker.sv -----
// Checker for the sine force Verlet step unit: predicts each output beat and compares it.
`timescale 1ns / 1ps

module sine_force_verlet_step_unit_checker import sfvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_t         in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_t        out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	localparam longint POS_LIMIT = 64'sd2147483647;
	localparam longint NEG_LIMIT = -64'sd2147483648;

	cfg_t               regs;
	logic signed [31:0] pos_now;
	logic signed [31:0] vel_now;
	logic signed [31:0] force_now;
	int                 step_count;
	logic [15:0]        quarter_sine [SINE_ENTRIES];
	out_t               expected_beats [$];
	int                 error_count;

	initial begin
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] e;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			x = (HALF_PI_Q30 * 64'(2 * i + 1)) / 64'(2 * SINE_ENTRIES);
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int n = 1; n <= 7; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			e = ((sum << 16) + (64'd1 << 29)) >> 30;
			if (e > 64'd65535) begin
				e = 64'd65535;
			end
			quarter_sine[i] = e[15:0];
		end
	end

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > POS_LIMIT) begin
			return 32'h7FFFFFFF;
		end
		if (v < NEG_LIMIT) begin
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic longint sine_sample(logic signed [31:0] y);
		logic [63:0]            prod;
		logic [31:0]            phase;
		logic [SINE_ADDR_W-1:0] idx;
		longint                 s;
		prod = {{32{y[31]}}, y} * {32'd0, regs.phase_per_unit};
		phase = prod[47:16];
		idx = phase[29 -: SINE_ADDR_W];
		if (phase[30]) begin
			idx = SINE_ADDR_W'(SINE_ENTRIES - 1) - idx;
		end
		s = {48'd0, quarter_sine[idx]};
		return phase[31] ? -s : s;
	endfunction

	function automatic logic signed [31:0] force_at(logic signed [31:0] y);
		return clamp32((longint'(regs.force_gain) * sine_sample(y)) >>> 16);
	endfunction

	function automatic logic signed [31:0] kick(logic signed [31:0] v, logic signed [31:0] f);
		return clamp32(longint'(v) +
			((longint'(f) * longint'({1'b0, regs.half_time_step})) >>> 16));
	endfunction

	function automatic out_t verlet_advance(in_t beat);
		out_t               r;
		logic signed [31:0] half_vel;
		if (beat.start_req) begin
			pos_now = beat.initial_position;
			vel_now = '0;
			step_count = 0;
			force_now = force_at(pos_now);
		end
		r.step_index = STEP_W'(step_count);
		r.last_step = (step_count == RUN_LENGTH - 1);
		half_vel = kick(vel_now, force_now);
		pos_now = clamp32(longint'(pos_now) +
			((longint'(half_vel) * longint'({1'b0, regs.time_step})) >>> 16));
		force_now = force_at(pos_now);
		vel_now = kick(half_vel, force_now);
		step_count = (step_count == RUN_LENGTH - 1) ? 0 : step_count + 1;
		r.position = pos_now;
		r.velocity = vel_now;
		return r;
	endfunction

	task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			if (error_count < 10) begin
				$display("%s mismatch: expected %0h, got %0h", field, want, got);
			end
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			regs.force_gain = '0;
			regs.time_step = 31'd23999;
			regs.half_time_step = 31'd12000;
			regs.phase_per_unit = '0;
			pos_now = '0;
			vel_now = '0;
			force_now = '0;
			step_count = 0;
			expected_beats.delete();
			error_count = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FORCE_GAIN:     regs.force_gain = cfg_data;
					CFG_TIME_STEP:      regs.time_step = cfg_data[30:0];
					CFG_HALF_TIME_STEP: regs.half_time_step = cfg_data[30:0];
					CFG_PHASE_PER_UNIT: regs.phase_per_unit = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				expected_beats.push_back(verlet_advance(in_data));
			end
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					if (error_count < 10) begin
						$display("unexpected output beat: step_index %0d", out_data.step_index);
					end
					error_count++;
				end else begin
					want = expected_beats.pop_front();
					compare_field("step_index", 32'(want.step_index), 32'(out_data.step_index));
					compare_field("position", want.position, out_data.position);
					compare_field("velocity", want.velocity, out_data.velocity);
					compare_field("last_step", 32'(want.last_step), 32'(out_data.last_step));
				end
			end
			outstanding <= expected_beats.size();
			mismatches <= error_count;
		end
	end

endmodule

// ----- dv/sine_force_verlet_step_unit_tb.sv -----
// Testbench top of the sine force Verlet step unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sine_force_verlet_step_unit_tb;
	import sfvs_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 300;
	localparam int QUIET_ITEMS = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_t        out_data;
	logic        cfg_we = 1'b0;
	cfg_index_t  cfg_index = CFG_FORCE_GAIN;
	logic [31:0] cfg_data = '0;
	int          mismatches;
	int          outstanding;
	int          items_sent = 0;
	bit          quiet = 1'b0;
	bit          pressure_done = 1'b0;
	int          idle_cycles = 0;

	always #6 clk = ~clk;

	sine_force_verlet_step_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sine_force_verlet_step_unit_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// The output side stalls in bursts; once it holds off long enough for the unit to fill up.
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (!pressure_done && items_sent >= 100) begin
				pressure_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	task automatic offer(logic start, logic [31:0] position);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{start_req: start, initial_position: position};
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic load_registers(logic [31:0] gain, logic [30:0] dt, logic [30:0] half_dt,
			logic [31:0] turns);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FORCE_GAIN;
		cfg_data <= gain;
		@(posedge clk);
		cfg_index <= CFG_TIME_STEP;
		cfg_data <= {1'($urandom), dt};
		@(posedge clk);
		cfg_index <= CFG_HALF_TIME_STEP;
		cfg_data <= {1'($urandom), half_dt};
		@(posedge clk);
		cfg_index <= CFG_PHASE_PER_UNIT;
		cfg_data <= turns;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_registers(bit wild);
		logic [31:0] gain;
		logic [30:0] dt;
		logic [30:0] half_dt;
		if (wild) begin
			gain = $urandom;
			dt = 31'($urandom);
			half_dt = 31'($urandom);
		end else begin
			gain = $urandom_range(0, 32'h80000) - 32'h40000;
			dt = 31'($urandom_range(0, 32'h20000));
			half_dt = dt >> 1;
		end
		load_registers(gain, dt, half_dt, $urandom);
	endtask

	function automatic logic [31:0] random_position();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h7FFFF) - 32'h40000;
			2: return $urandom_range(0, 32'h1FFFFFF) - 32'h1000000;
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFFFFFF;
					1: return 32'h80000000;
					2: return 32'hFFFFFFFF;
					default: return 32'h0;
				endcase
			end
		endcase
	endfunction

	// Mostly runs of plain steps after a start beat, with stray start beats mixed in.
	task automatic run_phase(int count);
		int done;
		int len;
		done = 0;
		while (done < count) begin
			offer(1'b1, random_position());
			done++;
			len = $urandom_range(0, 40);
			repeat (len) begin
				if ($urandom_range(0, 9) == 0) begin
					offer(1'($urandom), $urandom);
				end else begin
					offer(1'b0, $urandom);
				end
				done++;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(1'b0, 32'h7FFFFFFF);
		offer(1'b1, 32'h0);
		drain();

		load_registers(32'h00020000, 31'd23999, 31'd12000, 32'h10000000);
		offer(1'b1, 32'h7FFFFFFF);
		offer(1'b0, 32'h0);
		offer(1'b1, 32'h80000000);
		offer(1'b0, 32'hFFFFFFFF);
		offer(1'b1, 32'hFFFFFFFF);
		offer(1'b1, 32'h00000001);
		offer(1'b1, 32'h00010000);
		repeat (3) offer(1'b0, $urandom);
		drain();

		load_registers(32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF);
		offer(1'b1, 32'h00004000);
		repeat (3) offer(1'b0, 32'h0);
		offer(1'b1, 32'h80000000);
		offer(1'b0, 32'h0);
		drain();

		load_registers(32'h80000000, 31'd0, 31'd0, 32'h40000000);
		offer(1'b1, 32'h00008000);
		offer(1'b0, 32'h0);
		offer(1'b1, 32'hFFFF8000);
		offer(1'b0, 32'h0);
		drain();

		random_registers(1'b0);
		run_phase(PHASE_ITEMS);
		drain();
		random_registers(1'b1);
		run_phase(PHASE_ITEMS);
		drain();
		random_registers(1'b0);
		run_phase(PHASE_ITEMS);
		drain();
		random_registers($urandom_range(0, 1));
		run_phase(PHASE_ITEMS);
		drain();

		// A long run of plain steps with no idling on either side.
		quiet = 1'b1;
		load_registers(32'h00018000, 31'd23999, 31'd12000, 32'h0A000000);
		offer(1'b1, 32'h00030000);
		repeat (QUIET_ITEMS) offer(1'b0, $urandom);
		drain();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
